@@ hdl/pal_pkg.sv @@
`timescale 1ns / 1ps

package pal_pkg;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_INSERT     = 3'd2;
  localparam logic [2:0] CMD_ERASE      = 3'd3;
  localparam logic [2:0] CMD_FIND       = 3'd4;
  localparam logic [2:0] CMD_MODIFY     = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BADPOS   = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    COP_HOLD,
    COP_WRITE_AT,
    COP_SHIFT_UP,
    COP_SHIFT_DOWN,
    COP_MATCH,
    COP_MATCH_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

@@ hdl/pal_cell.sv @@
`timescale 1ns / 1ps

module pal_cell import pal_pkg::*; #(
  parameter int IDX        = 0,
  parameter int CNT_W      = 11,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]      pos_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic                  match_right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  match_q, match_d;
  logic                  at_pos, above_pos, in_list;

  assign at_pos    = (MyIdx == pos_i);
  assign above_pos = (MyIdx > pos_i);
  assign in_list   = (MyIdx < count_i);

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    unique case (ctrl_i.op)
      COP_HOLD: begin
      end
      COP_WRITE_AT: begin
        if (at_pos) data_d = value_i;
      end
      COP_SHIFT_UP: begin
        if (above_pos) data_d = left_i;
        else if (at_pos) data_d = value_i;
      end
      COP_SHIFT_DOWN: begin
        if (above_pos || at_pos) data_d = right_i;
      end
      COP_MATCH: begin
        match_d = in_list && (data_q == value_i);
      end
      COP_MATCH_SHIFT: begin
        match_d = match_right_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

@@ hdl/positional_array_list.sv @@
`timescale 1ns / 1ps
// Push, insert, erase and modify: result registered in the cycle after the transfer.
// Find: result registered once a group holds a match or the last group is searched; match flags move
// down the cell row 32 places a cycle and one group of 32 is encoded per cycle.
// Throughput: one item per cycle while each result is taken, except find, which holds input until it answers.
// Reset clears the element count and handshake; stored entries are not cleared.
module positional_array_list import pal_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int IdxW = $clog2(CAPACITY),
  localparam int CntW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   command_i,
  input  logic [CntW-1:0]              position_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [IdxW-1:0]              found_index_o,
  output logic [CntW-1:0]              element_count_o
);

  localparam int GrpBits = (IdxW < 5) ? IdxW : 5;
  localparam int GrpSize = 1 << GrpBits;
  localparam int GrpW    = IdxW - GrpBits + 1;
  localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e             state_q;
  logic               out_valid_q;
  logic [1:0]         status_q, status_d;
  logic [IdxW-1:0]    found_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [GrpW-1:0]    grp_q, last_grp_q, last_grp_d;
  logic [CntW-1:0]    count_m1;

  logic               in_fire, respond_now, go_search, resp_set;
  cell_ctrl_t         ctrl;
  logic [CntW-1:0]    pos_sel;

  logic [DATA_WIDTH-1:0] data_w [CAPACITY];
  logic [CAPACITY-1:0]   match_w;

  logic                 hit;
  logic [GrpBits-1:0]   enc;
  logic [IdxW:0]        found_full;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign count_m1   = count_q - 1'b1;
  assign last_grp_d = GrpW'(count_m1 >> GrpBits);

  always_comb begin
    ctrl.op     = COP_HOLD;
    pos_sel     = position_i;
    status_d    = STAT_OK;
    count_d     = count_q;
    respond_now = 1'b0;
    go_search   = 1'b0;
    if (state_q == S_SEARCH) begin
      ctrl.op = COP_MATCH_SHIFT;
    end else if (in_fire) begin
      respond_now = 1'b1;
      unique case (command_i)
        CMD_PUSH_BACK: begin
          if (count_q == Full) begin
            status_d = STAT_FULL;
          end else begin
            ctrl.op = COP_WRITE_AT;
            pos_sel = count_q;
            count_d = count_q + 1'b1;
          end
        end
        CMD_PUSH_FRONT: begin
          if (count_q == Full) begin
            status_d = STAT_FULL;
          end else begin
            ctrl.op = COP_SHIFT_UP;
            pos_sel = '0;
            count_d = count_q + 1'b1;
          end
        end
        CMD_INSERT: begin
          if (position_i > count_q) begin
            status_d = STAT_BADPOS;
          end else if (count_q == Full) begin
            status_d = STAT_FULL;
          end else begin
            ctrl.op = COP_SHIFT_UP;
            count_d = count_q + 1'b1;
          end
        end
        CMD_ERASE: begin
          if (position_i >= count_q) begin
            status_d = STAT_BADPOS;
          end else begin
            ctrl.op = COP_SHIFT_DOWN;
            count_d = count_m1;
          end
        end
        CMD_FIND: begin
          if (count_q == '0) begin
            status_d = STAT_NOTFOUND;
          end else begin
            ctrl.op     = COP_MATCH;
            respond_now = 1'b0;
            go_search   = 1'b1;
          end
        end
        CMD_MODIFY: begin
          if (position_i >= count_q) begin
            status_d = STAT_BADPOS;
          end else begin
            ctrl.op = COP_WRITE_AT;
          end
        end
        default: begin
          status_d = STAT_BADPOS;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    logic                  match_right;
    if (i == 0) begin : g_first
      assign left = data_w[i];
    end else begin : g_mid_left
      assign left = data_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = data_w[i];
    end else begin : g_mid_right
      assign right = data_w[i+1];
    end
    if (i + GrpSize < CAPACITY) begin : g_mr
      assign match_right = match_w[i+GrpSize];
    end else begin : g_mr_end
      assign match_right = 1'b0;
    end
    pal_cell #(
      .IDX       (i),
      .CNT_W     (CntW),
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .pos_i        (pos_sel),
      .count_i      (count_q),
      .value_i      (value_i),
      .left_i       (left),
      .right_i      (right),
      .match_right_i(match_right),
      .data_o       (data_w[i]),
      .match_o      (match_w[i])
    );
  end

  always_comb begin
    hit = 1'b0;
    enc = '0;
    for (int k = GrpSize - 1; k >= 0; k--) begin
      if (match_w[k]) begin
        hit = 1'b1;
        enc = GrpBits'(k);
      end
    end
  end

  assign found_full = {grp_q, enc};
  assign resp_set   = respond_now ||
                      ((state_q == S_SEARCH) && (hit || (grp_q == last_grp_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= STAT_OK;
      found_q     <= '0;
      count_q     <= '0;
      grp_q       <= '0;
      last_grp_q  <= '0;
    end else begin
      if (resp_set) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (respond_now) begin
            status_q    <= status_d;
            found_q     <= '0;
            count_q     <= count_d;
          end else if (go_search) begin
            state_q    <= S_SEARCH;
            grp_q      <= '0;
            last_grp_q <= last_grp_d;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            state_q     <= S_IDLE;
            status_q    <= STAT_OK;
            found_q     <= found_full[IdxW-1:0];
          end else if (grp_q == last_grp_q) begin
            state_q     <= S_IDLE;
            status_q    <= STAT_NOTFOUND;
            found_q     <= '0;
          end else begin
            grp_q <= grp_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign found_index_o   = found_q;
  assign element_count_o = count_q;

endmodule

@@ test/tb_positional_array_list.sv @@
`timescale 1ns / 1ps

module tb_positional_array_list;
  import pal_pkg::*;

  localparam int CAP   = 1024;
  localparam int DW    = 32;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);

  typedef struct {
    logic [2:0]           cmd;
    logic [CNT_W-1:0]     pos;
    logic signed [DW-1:0] val;
  } list_cmd_t;

  typedef struct {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } list_result_t;

  typedef enum int {MODE_MIX, MODE_GROW, MODE_SHRINK} gen_mode_e;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [2:0]                   command = CMD_PUSH_BACK;
  logic [CNT_W-1:0]             position = '0;
  logic signed [DW-1:0]         value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   status;
  logic [IDX_W-1:0]             found_index;
  logic [CNT_W-1:0]             element_count;

  logic signed [DW-1:0] list_mem [CAP];
  int                   list_len = 0;
  list_cmd_t            pending_items [$];
  list_result_t         due_results [$];
  int                   send_idle_pct = 0;
  int                   rx_stall_pct = 0;
  logic                 hold_start = 1'b0;
  logic                 rx_hold = 1'b0;
  int                   errors = 0;

  positional_array_list #(
    .CAPACITY  (CAP),
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .position_i     (position),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .found_index_o  (found_index),
    .element_count_o(element_count)
  );

  always #5 clk = ~clk;

  function automatic list_result_t list_command_result(logic [2:0] cmd, logic [CNT_W-1:0] pos,
                                                       logic signed [DW-1:0] val);
    list_result_t r;
    r.status = STAT_OK;
    r.index  = '0;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (list_len >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      CMD_PUSH_FRONT, CMD_INSERT: begin
        if (cmd == CMD_PUSH_FRONT) pos = '0;
        if (int'(pos) > list_len) begin
          r.status = STAT_BADPOS;
        end else if (list_len >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[pos[IDX_W-1:0]] = val;
          list_len++;
        end
      end
      CMD_ERASE: begin
        if (int'(pos) >= list_len) begin
          r.status = STAT_BADPOS;
        end else begin
          for (int i = int'(pos); i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      CMD_FIND: begin
        r.status = STAT_NOTFOUND;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            r.status = STAT_OK;
            r.index  = IDX_W'(i);
            break;
          end
        end
      end
      CMD_MODIFY: begin
        if (int'(pos) >= list_len) r.status = STAT_BADPOS;
        else list_mem[pos[IDX_W-1:0]] = val;
      end
      default: r.status = STAT_BADPOS;
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  // transfer in: predict, then offer the next item or idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        due_results.push_back(list_command_result(command, position, value));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          command  <= pending_items[0].cmd;
          position <= pending_items[0].pos;
          value    <= pending_items[0].val;
          pending_items.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // transfer out: compare with the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d, found_index %0d, element_count %0d",
                 status, found_index, element_count);
          errors++;
        end else begin
          if (status !== due_results[0].status) begin
            $error("status: expected %0d, got %0d", due_results[0].status, status);
            errors++;
          end
          if (found_index !== due_results[0].index) begin
            $error("found_index: expected %0d, got %0d", due_results[0].index, found_index);
            errors++;
          end
          if (element_count !== due_results[0].count) begin
            $error("element_count: expected %0d, got %0d", due_results[0].count,
                   element_count);
            errors++;
          end
          due_results.delete(0);
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_start);
    @(negedge clk) rx_hold = 1'b1;
    repeat (400) @(negedge clk);
    rx_hold = 1'b0;
  end

  task automatic send(logic [2:0] cmd, logic [CNT_W-1:0] pos, logic signed [DW-1:0] val);
    list_cmd_t it;
    it.cmd = cmd;
    it.pos = pos;
    it.val = val;
    while (pending_items.size() >= 2) @(negedge clk);
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (!(pending_items.size() == 0 && !in_valid && due_results.size() == 0));
  endtask

  function automatic logic signed [DW-1:0] pick_value(int stored_pct);
    int r;
    r = $urandom_range(99);
    if (list_len > 0 && r < stored_pct) return list_mem[$urandom_range(list_len - 1)];
    if (r < stored_pct + 25) return DW'($signed($urandom_range(8)) - 4);
    return $urandom;
  endfunction

  task automatic send_random(gen_mode_e mode);
    int               r;
    logic [2:0]       cmd;
    logic [CNT_W-1:0] pos;
    r = $urandom_range(99);
    case (mode)
      MODE_GROW:
        cmd = r < 40 ? CMD_PUSH_BACK : r < 60 ? CMD_PUSH_FRONT : r < 92 ? CMD_INSERT :
              r < 96 ? CMD_FIND : CMD_MODIFY;
      MODE_SHRINK:
        cmd = r < 70 ? CMD_ERASE : r < 80 ? CMD_FIND : r < 90 ? CMD_MODIFY : CMD_PUSH_BACK;
      default:
        cmd = r < 14 ? CMD_PUSH_BACK : r < 24 ? CMD_PUSH_FRONT : r < 40 ? CMD_INSERT :
              r < 58 ? CMD_ERASE : r < 80 ? CMD_FIND : r < 96 ? CMD_MODIFY :
              r < 98 ? CMD_SPARE_6 : CMD_SPARE_7;
    endcase
    r = $urandom_range(99);
    if (cmd == CMD_INSERT) begin
      pos = r < 90 ? CNT_W'($urandom_range(list_len)) : CNT_W'($urandom_range(CAP));
    end else if (cmd == CMD_ERASE || cmd == CMD_MODIFY) begin
      pos = (r < 90 && list_len > 0) ? CNT_W'($urandom_range(list_len - 1)) :
                                       CNT_W'($urandom_range(CAP));
    end else begin
      pos = CNT_W'($urandom);
    end
    send(cmd, pos, pick_value(cmd == CMD_FIND ? 70 : 15));
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(CMD_ERASE, 0, 5);
    send(CMD_MODIFY, 0, 5);
    send(CMD_FIND, 0, 0);
    send(CMD_SPARE_6, 0, 1);
    send(CMD_SPARE_7, 1024, -1);
    send(CMD_PUSH_BACK, 2047, 32'h7fff_ffff);
    send(CMD_PUSH_FRONT, 0, 32'h8000_0000);
    send(CMD_INSERT, 2, 0);
    send(CMD_INSERT, 0, -1);
    send(CMD_INSERT, 5, 9);
    send(CMD_FIND, 0, -1);
    send(CMD_FIND, 3, 0);
    send(CMD_FIND, 0, 123);
    send(CMD_MODIFY, 1, 32'h5555_5555);
    send(CMD_MODIFY, 4, 7);
    send(CMD_FIND, 0, 32'h5555_5555);
    send(CMD_ERASE, 3, 0);
    send(CMD_ERASE, 0, 0);
    send(CMD_INSERT, 1024, 3);
    send(CMD_ERASE, 1024, 3);
    send(CMD_FIND, 0, 32'h7fff_ffff);

    for (n = 0; n < 120; n++) begin
      if (n == 60) hold_start = 1'b1;
      send_random(MODE_MIX);
    end

    for (n = 0; n < 60; n++) send_random(MODE_GROW);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      send_idle_pct = ph == 0 ? 66 : ph == 1 ? 0 : 14;
      rx_stall_pct  = ph == 0 ? 0 : ph == 1 ? 66 : 14;
      for (n = 0; n < 250; n++) send_random(n % 100 < 80 ? MODE_MIX : MODE_SHRINK);
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
